>>> hdl/port_number_pool_allocator_macros.svh
// Assertion macros for the port number pool allocator.
// Included by the top level; the bodies are empty when SYNTHESIS is defined.
`ifndef PORT_NUMBER_POOL_ALLOCATOR_MACROS_SVH
`define PORT_NUMBER_POOL_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define PNPA_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pnpa: invariant violated");

// When the antecedent holds, the consequent sequence follows from the next edge on.
`define PNPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("pnpa: sequence violated");

`else

`define PNPA_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define PNPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/pnpa_pkg.sv
// Shared constants, codes and control structs of the port number pool allocator.
// Has no dependencies; every module of the block imports it.
package pnpa_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
    localparam int PORT_W     = 16;
    localparam int OUT_CNT_W  = 9;

    localparam logic [PORT_W-1:0] RANGE_START_RESET = 16'd10000;
    localparam logic [PORT_W-1:0] RANGE_END_RESET   = 16'd10255;

    localparam logic CFG_RANGE_START = 1'b0;
    localparam logic CFG_RANGE_END   = 1'b1;

    typedef enum logic [1:0] {
        MODE_ACQUIRE = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_REBUILD = 2'd2
    } t_mode;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic              clear;
        logic              push;
        logic              pop;
        logic [PORT_W-1:0] data;
    } t_stack_op;

    typedef struct packed {
        logic             set;
        logic             clr;
        logic [IDX_W-1:0] idx;
    } t_map_op;

endpackage

>>> hdl/port_number_pool_allocator.sv
// Top level of the port number pool allocator: request register, allocation logic, result.
// Depends on pnpa_pkg, pnpa_stack, pnpa_map and the assertion macro header.
//
// A request (acquire, release or rebuild) is taken when start is high and busy is low;
// busy is high during reset and for the first cycle after it, so from then on one request
// can enter every clock cycle. Each request gives exactly one result: the request is held
// in r_in_valid, then o_done and the result ports are driven for one cycle from r_done,
// r_granted and r_status, and the result is taken at the edge that ends that cycle; the
// receiver cannot stall it, so results must be taken as they appear. Released ports sit
// in a 256-entry memory with the top two entries kept in registers, so back-to-back
// acquires pop one port per cycle. The in-use flags sit in a 256-entry memory that is
// read while the request is being taken; a rebuild leaves them in place, since only
// ports issued after the rebuild are looked up. The pool is empty after reset until the
// first rebuild. Range registers should be written only while no request is in flight.
`include "port_number_pool_allocator_macros.svh"

module port_number_pool_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_mode,
    input  logic [pnpa_pkg::PORT_W-1:0]    i_port,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [pnpa_pkg::PORT_W-1:0]    i_cfg_data,
    output logic                           o_done,
    output logic [pnpa_pkg::PORT_W-1:0]    o_granted_port,
    output logic [1:0]                     o_status,
    output logic [pnpa_pkg::OUT_CNT_W-1:0] o_ports_in_use,
    output logic [pnpa_pkg::OUT_CNT_W-1:0] o_ports_free
);
    import pnpa_pkg::*;

    logic              r_busy;
    logic [PORT_W-1:0] r_range_start;
    logic [PORT_W-1:0] r_range_end;

    logic              r_in_valid;
    logic [1:0]        r_in_mode;
    logic [PORT_W-1:0] r_in_port;

    logic [PORT_W-1:0] r_base, n_base;
    logic [PORT_W-1:0] r_end, n_end;
    logic [PORT_W-1:0] r_next_fresh, n_next_fresh;
    logic [CNT_W-1:0]  r_fresh_left, n_fresh_left;
    logic [CNT_W-1:0]  r_total, n_total;

    logic              r_done;
    logic [PORT_W-1:0] r_granted, n_granted;
    logic [1:0]        r_status, n_status;

    t_stack_op         stk_op;
    t_map_op           map_op;
    logic [PORT_W-1:0] stk_top;
    logic [CNT_W-1:0]  stk_count;
    logic              map_hit;

    logic              accept;
    logic [PORT_W-1:0] acq_port;
    logic [PORT_W-1:0] acq_off;
    logic [PORT_W-1:0] rel_off;
    logic              rel_in_range;
    logic [PORT_W-1:0] issued;
    logic              rel_issued;
    logic [IDX_W-1:0]  rd_idx;

    logic [PORT_W-1:0] rb_start;
    logic [PORT_W:0]   rb_lim;
    logic              rb_empty;
    logic [PORT_W-1:0] rb_end;
    logic [PORT_W:0]   rb_size;
    logic [CNT_W:0]    free_sum;

    assign accept      = start && !busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b1;
            r_range_start <= RANGE_START_RESET;
            r_range_end   <= RANGE_END_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_RANGE_START: r_range_start <= i_cfg_data;
                    CFG_RANGE_END:   r_range_end   <= i_cfg_data;
                    default:         r_range_start <= r_range_start;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
        if (accept) begin
            r_in_mode <= i_mode;
            r_in_port <= i_port;
        end
    end

    // Rebuild bounds: a start of zero counts as one, and the pool is clamped in length.
    assign rb_start = (r_range_start == '0) ? PORT_W'(1) : r_range_start;
    assign rb_lim   = {1'b0, rb_start} + (PORT_W + 1)'(POOL_DEPTH - 1);
    assign rb_empty = r_range_end < rb_start;
    assign rb_end   = rb_empty ? (rb_start - PORT_W'(1))
                    : (({1'b0, r_range_end} < rb_lim) ? r_range_end : rb_lim[PORT_W-1:0]);
    assign rb_size  = {1'b0, rb_end} - {1'b0, rb_start} + (PORT_W + 1)'(1);

    assign rel_off      = r_in_port - r_base;
    assign rel_in_range = (r_in_port != '0) && (r_in_port >= r_base) && (r_in_port <= r_end);
    // Offsets below the fresh pointer are the only ones handed out since the last rebuild.
    assign issued       = r_next_fresh - r_base;
    assign rel_issued   = rel_off < issued;
    // The flag of an incoming release is looked up against the base that holds after the
    // transaction now in progress.
    assign rd_idx       = IDX_W'(i_port - n_base);

    always_comb begin
        stk_op       = '0;
        map_op       = '0;
        n_base       = r_base;
        n_end        = r_end;
        n_next_fresh = r_next_fresh;
        n_fresh_left = r_fresh_left;
        n_total      = r_total;
        n_granted    = '0;
        n_status     = ST_DONE;
        acq_port     = (stk_count != '0) ? stk_top : r_next_fresh;
        acq_off      = acq_port - r_base;
        stk_op.data  = r_in_port;
        map_op.idx   = rel_off[IDX_W-1:0];
        if (r_in_valid) begin
            unique case (r_in_mode)
                MODE_ACQUIRE: begin
                    map_op.idx = acq_off[IDX_W-1:0];
                    if (stk_count != '0 || r_fresh_left != '0) begin
                        if (stk_count != '0) begin
                            stk_op.pop = 1'b1;
                        end else begin
                            n_next_fresh = r_next_fresh + PORT_W'(1);
                            n_fresh_left = r_fresh_left - CNT_W'(1);
                        end
                        map_op.set = 1'b1;
                        n_total    = r_total + CNT_W'(1);
                        n_granted  = acq_port;
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
                MODE_RELEASE: begin
                    if (rel_in_range && rel_issued && map_hit &&
                        (stk_count < CNT_W'(POOL_DEPTH))) begin
                        map_op.clr  = 1'b1;
                        stk_op.push = 1'b1;
                        if (r_total != '0) begin
                            n_total = r_total - CNT_W'(1);
                        end
                    end else begin
                        n_status = ST_IGNORED;
                    end
                end
                MODE_REBUILD: begin
                    stk_op.clear = 1'b1;
                    n_total      = '0;
                    n_base       = rb_start;
                    n_next_fresh = rb_start;
                    n_end        = rb_end;
                    n_fresh_left = rb_empty ? '0 : CNT_W'(rb_size);
                end
                default: begin
                    // The unused mode code does nothing and reports the counts.
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= PORT_W'(1);
            r_end        <= '0;
            r_next_fresh <= PORT_W'(1);
            r_fresh_left <= '0;
            r_total      <= '0;
            r_done       <= 1'b0;
        end else begin
            r_base       <= n_base;
            r_end        <= n_end;
            r_next_fresh <= n_next_fresh;
            r_fresh_left <= n_fresh_left;
            r_total      <= n_total;
            r_done       <= r_in_valid;
        end
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    pnpa_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (stk_op),
        .o_top   (stk_top),
        .o_count (stk_count)
    );

    pnpa_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (map_op),
        .i_rd_idx (rd_idx),
        .o_hit    (map_hit)
    );

    // The state registers already hold the counts after the transaction in the result cycle.
    assign free_sum       = {1'b0, stk_count} + {1'b0, r_fresh_left};
    assign o_done         = r_done;
    assign o_granted_port = r_granted;
    assign o_status       = r_status;
    assign o_ports_in_use = OUT_CNT_W'(r_total);
    assign o_ports_free   = OUT_CNT_W'(free_sum);

    `PNPA_ASSERT_ALWAYS(a_pool_conserved, i_clk, i_rst_n, (int'(r_total) + int'(stk_count) + int'(r_fresh_left)) <= POOL_DEPTH)
    `PNPA_ASSERT_ALWAYS(a_stack_bounded, i_clk, i_rst_n, int'(stk_count) <= POOL_DEPTH)
    `PNPA_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, ##1 o_done)
    `PNPA_ASSERT_ALWAYS(a_grant_only_done, i_clk, i_rst_n, !o_done || (o_status == ST_DONE) || (o_granted_port == '0))

endmodule

>>> hdl/pnpa_stack.sv
// Released-port stack: entries live in a memory, the top two are cached in registers.
// Depends on pnpa_pkg.
module pnpa_stack (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pnpa_pkg::t_stack_op       i_op,
    output logic [pnpa_pkg::PORT_W-1:0] o_top,
    output logic [pnpa_pkg::CNT_W-1:0]  o_count
);
    import pnpa_pkg::*;

    logic [PORT_W-1:0] mem [POOL_DEPTH];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PORT_W-1:0] r_top, n_top;
    logic [PORT_W-1:0] r_sec_hold, n_sec_hold;
    logic              r_sec_sel, n_sec_sel;
    logic [PORT_W-1:0] r_rd;
    logic [PORT_W-1:0] sec;
    logic [CNT_W-1:0]  rd_cnt;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;

    // The entry below the top is either held or comes straight from the memory read.
    assign sec     = r_sec_sel ? r_rd : r_sec_hold;
    // A pop needs the third entry from the current top to refill the second slot.
    assign rd_cnt  = r_count - CNT_W'(3);
    assign rd_addr = rd_cnt[IDX_W-1:0];
    assign wr_addr = r_count[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            mem[wr_addr] <= i_op.data;
        end
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        n_count    = r_count;
        n_top      = r_top;
        n_sec_hold = sec;
        n_sec_sel  = 1'b0;
        priority if (i_op.clear) begin
            n_count = '0;
        end else if (i_op.push) begin
            n_count    = r_count + CNT_W'(1);
            n_top      = i_op.data;
            n_sec_hold = r_top;
        end else if (i_op.pop) begin
            n_count   = r_count - CNT_W'(1);
            n_top     = sec;
            n_sec_sel = 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sec_sel <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_sec_sel <= n_sec_sel;
        end
        r_top      <= n_top;
        r_sec_hold <= n_sec_hold;
    end

    assign o_top   = r_top;
    assign o_count = r_count;

endmodule

>>> hdl/pnpa_map.sv
// In-use flags over the pool, one per port offset, kept in a memory with a registered read.
// Depends on pnpa_pkg.
module pnpa_map (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pnpa_pkg::t_map_op          i_op,
    input  logic [pnpa_pkg::IDX_W-1:0] i_rd_idx,
    output logic                       o_hit
);
    import pnpa_pkg::*;

    logic mem [POOL_DEPTH];
    logic r_rd;
    logic r_fwd_hit;
    logic r_fwd_val;
    logic wr_en;

    // Flags are never cleared in bulk: only offsets issued since the last rebuild are
    // looked up, and each of them was written when it was issued.
    assign wr_en = i_op.set || i_op.clr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_op.idx] <= i_op.set;
        end
        r_rd <= mem[i_rd_idx];
    end

    // A flag written in the same cycle as it is read is taken from the write side.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= wr_en && (i_op.idx == i_rd_idx);
        end
        r_fwd_val <= i_op.set;
    end

    assign o_hit = r_fwd_hit ? r_fwd_val : r_rd;

endmodule
